// ----- design/cbm_pkg.sv -----
`default_nettype none

package cbm_pkg;

    // field widths
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned ROM_W      = 23;
    localparam int unsigned RAM_W      = 17;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned ROM_BANK_W = 9;
    localparam int unsigned RAM_BANK_W = 4;
    localparam int unsigned ROM_OFS_W  = 14;
    localparam int unsigned RAM_OFS_W  = 13;

    // default physical address widths
    localparam int unsigned ROM_ADDR_BITS_DEF = 23;
    localparam int unsigned RAM_ADDR_BITS_DEF = 17;

    // command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // target codes
    localparam logic [1:0] TGT_ROM  = 2'd0;
    localparam logic [1:0] TGT_RAM  = 2'd1;
    localparam logic [1:0] TGT_REG  = 2'd2;
    localparam logic [1:0] TGT_NONE = 2'd3;

    // mapper kinds; anything above MBC3 behaves as MBC5
    localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MBC3 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MBC5 = 2'd2;

    // register window codes: bus_address[14:12]
    localparam logic [2:0] WIN_RAMEN_0 = 3'd0;
    localparam logic [2:0] WIN_RAMEN_1 = 3'd1;
    localparam logic [2:0] WIN_ROMB_LO = 3'd2;
    localparam logic [2:0] WIN_ROMB_HI = 3'd3;
    localparam logic [2:0] WIN_RAMB_0  = 3'd4;
    localparam logic [2:0] WIN_RAMB_1  = 3'd5;

    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 9'd1;
    localparam logic [DATA_W-1:0]     RAM_EN_KEY     = 8'h0A;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [1:0]       target;
        logic [ROM_W-1:0] rom_address;
        logic [RAM_W-1:0] ram_address;
        logic             read_zero;
        logic             ram_disabled_error;
    } rsp_item_t;

    typedef struct packed {
        logic                  ram_enable;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank_latch;
        logic [RAM_BANK_W-1:0] eff_ram_bank;
        logic                  bank_mode;
        logic                  rtc_active;
    } bank_state_t;

    typedef struct packed {
        logic              en;
        logic [2:0]        win;
        logic [DATA_W-1:0] data;
    } bank_write_t;

endpackage

`default_nettype wire

// ----- design/cbm_bank_regs.sv -----
`default_nettype none

// Bank register file; updated by writes below 0x8000.
module cbm_bank_regs
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire logic [cbm_pkg::KIND_W-1:0]  kind,
    input  wire cbm_pkg::bank_write_t        wr,
    output cbm_pkg::bank_state_t             state
);

    cbm_pkg::bank_state_t state_reg;
    cbm_pkg::bank_state_t state_next;

    logic [4:0] mbc1_bank;
    logic [6:0] mbc3_bank;

    assign mbc1_bank = (wr.data[4:0] == 5'd0) ? 5'd1 : wr.data[4:0];
    assign mbc3_bank = (wr.data[6:0] == 7'd0) ? 7'd1 : wr.data[6:0];

    always_comb
    begin
        state_next = state_reg;
        if (wr.en)
        begin
            if (wr.win == cbm_pkg::WIN_RAMEN_0 || wr.win == cbm_pkg::WIN_RAMEN_1)
            begin
                state_next.ram_enable =
                    ((wr.data & cbm_pkg::RAM_EN_KEY) == cbm_pkg::RAM_EN_KEY);
            end
            else if (kind == cbm_pkg::KIND_MBC1)
            begin
                case (wr.win)
                    cbm_pkg::WIN_ROMB_LO, cbm_pkg::WIN_ROMB_HI:
                        state_next.rom_bank = {4'd0, mbc1_bank};
                    cbm_pkg::WIN_RAMB_0, cbm_pkg::WIN_RAMB_1:
                        state_next.ram_bank_latch = {2'd0, wr.data[1:0]};
                    default:
                        state_next.bank_mode = wr.data[0];
                endcase
                // bank takes effect according to the (new) mode
                if (!state_next.bank_mode)
                begin
                    state_next.rom_bank = {2'd0, state_next.ram_bank_latch[1:0],
                                           state_next.rom_bank[4:0]};
                end
                else
                begin
                    state_next.rom_bank     = {4'd0, state_next.rom_bank[4:0]};
                    state_next.eff_ram_bank = state_next.ram_bank_latch;
                end
            end
            else if (kind == cbm_pkg::KIND_MBC3)
            begin
                case (wr.win)
                    cbm_pkg::WIN_ROMB_LO, cbm_pkg::WIN_ROMB_HI:
                        state_next.rom_bank = {2'd0, mbc3_bank};
                    cbm_pkg::WIN_RAMB_0, cbm_pkg::WIN_RAMB_1:
                    begin
                        if (wr.data > 8'd3)
                        begin
                            state_next.rtc_active = 1'b1;
                        end
                        else
                        begin
                            state_next.rtc_active     = 1'b0;
                            state_next.ram_bank_latch = {2'd0, wr.data[1:0]};
                            state_next.eff_ram_bank   = {2'd0, wr.data[1:0]};
                        end
                    end
                    default:
                        ; // mode register ignored
                endcase
            end
            else
            begin
                case (wr.win)
                    cbm_pkg::WIN_ROMB_LO:
                        state_next.rom_bank[7:0] = wr.data;
                    cbm_pkg::WIN_ROMB_HI:
                        state_next.rom_bank[8] = wr.data[0];
                    cbm_pkg::WIN_RAMB_0, cbm_pkg::WIN_RAMB_1:
                    begin
                        state_next.ram_bank_latch = wr.data[3:0];
                        state_next.eff_ram_bank   = wr.data[3:0];
                    end
                    default:
                        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.ram_enable     <= 1'b0;
            state_reg.rom_bank       <= cbm_pkg::ROM_BANK_RESET;
            state_reg.ram_bank_latch <= '0;
            state_reg.eff_ram_bank   <= '0;
            state_reg.bank_mode      <= 1'b0;
            state_reg.rtc_active     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ----- design/cbm_translate.sv -----
`default_nettype none

// Address decode and ROM/RAM translation against the current bank state.
module cbm_translate
#(
    parameter int unsigned ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
    parameter int unsigned RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
)
(
    input  wire cbm_pkg::req_item_t          req,
    input  wire cbm_pkg::bank_state_t        state,
    input  wire logic [cbm_pkg::KIND_W-1:0]  kind,
    output cbm_pkg::rsp_item_t               rsp,
    output cbm_pkg::bank_write_t             wr
);

    logic                               is_low;
    logic                               is_ram;
    logic [cbm_pkg::ROM_BANK_W-1:0]     rom_bank;
    logic [cbm_pkg::ROM_W-1:0]          rom_full;
    logic [cbm_pkg::RAM_W-1:0]          ram_full;

    assign is_low   = !req.bus_address[15];
    assign is_ram   = (req.bus_address[15:13] == 3'b101);
    // fixed area 0x0000-0x3FFF always maps bank 0
    assign rom_bank = req.bus_address[14] ? state.rom_bank : '0;
    assign rom_full = {rom_bank, req.bus_address[cbm_pkg::ROM_OFS_W-1:0]};
    assign ram_full = {state.eff_ram_bank, req.bus_address[cbm_pkg::RAM_OFS_W-1:0]};

    assign wr.en   = is_low && (req.command == cbm_pkg::CMD_WRITE);
    assign wr.win  = req.bus_address[14:12];
    assign wr.data = req.write_data;

    always_comb
    begin
        rsp = '0;
        if (is_low)
        begin
            if (req.command == cbm_pkg::CMD_WRITE)
            begin
                rsp.target = cbm_pkg::TGT_REG;
            end
            else
            begin
                rsp.target      = cbm_pkg::TGT_ROM;
                rsp.rom_address = cbm_pkg::ROM_W'(rom_full[ROM_ADDR_BITS-1:0]);
            end
        end
        else if (is_ram)
        begin
            rsp.target             = cbm_pkg::TGT_RAM;
            rsp.ram_address        = cbm_pkg::RAM_W'(ram_full[RAM_ADDR_BITS-1:0]);
            rsp.read_zero          = (kind == cbm_pkg::KIND_MBC3) && state.rtc_active;
            rsp.ram_disabled_error = !state.ram_enable;
        end
        else
        begin
            rsp.target = cbm_pkg::TGT_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- design/cartridge_bank_mapper_unit.sv -----
`default_nettype none

// Channel | Signals                          | Direction | Notes
// --------+----------------------------------+-----------+-------------------------------
// req     | req_valid, req_ready, req_data   | in        | one bus access per request
// rsp     | rsp_valid, rsp_ready, rsp_data   | out       | one translation result per request
// cfg     | cfg_valid, cfg_ready, cfg_data   | in        | mapper kind; always ready
//
// Two registers deep: a request lands in the input register, then its result moves to
// the result register, and rsp_valid rises as it is loaded. Throughput is one request
// per clock while rsp_ready is held. Bank registers update as a request moves to the
// result register, so each request sees the effect of all earlier writes. A stalled
// rsp holds the result register; the input register still fills, then req_ready drops
// until the result is taken. Reset: kind MBC1, bank state, valids.
module cartridge_bank_mapper_unit
#(
    parameter int unsigned ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
    parameter int unsigned RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              req_valid,
    output logic                             req_ready,
    input  wire cbm_pkg::req_item_t          req_data,

    output logic                             rsp_valid,
    input  wire                              rsp_ready,
    output cbm_pkg::rsp_item_t               rsp_data,

    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [cbm_pkg::KIND_W-1:0]  cfg_data
);

    // mapper kind register
    logic [cbm_pkg::KIND_W-1:0] kind_reg;

    // input register
    logic                       in_valid_reg;
    cbm_pkg::req_item_t         in_item_reg;

    // result register
    logic                       out_valid_reg;
    cbm_pkg::rsp_item_t         out_item_reg;

    cbm_pkg::bank_state_t       bank_state;
    cbm_pkg::bank_write_t       xlat_wr;
    cbm_pkg::bank_write_t       bank_wr;
    cbm_pkg::rsp_item_t         xlat_rsp;

    logic                       advance;   // input register moves to result register

    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // bank registers only change on the cycle the request is retired into
    // the result register
    always_comb
    begin
        bank_wr    = xlat_wr;
        bank_wr.en = xlat_wr.en && advance;
    end

    cbm_translate
    #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    )
    u_translate
    (
        .req   (in_item_reg),
        .state (bank_state),
        .kind  (kind_reg),
        .rsp   (xlat_rsp),
        .wr    (xlat_wr)
    );

    cbm_bank_regs u_bank_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .kind  (kind_reg),
        .wr    (bank_wr),
        .state (bank_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= cbm_pkg::KIND_MBC1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                kind_reg <= cfg_data;
            end

            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_item_reg <= req_data;
        end
        if (advance)
        begin
            out_item_reg <= xlat_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_item_reg;

endmodule

`default_nettype wire

// ----- test/cartridge_bank_mapper_unit_tb.sv -----
`timescale 1ns / 100ps

// Bank mapper bench: bus requests go in through a queue-fed driver; every request
// is run through a behavioral copy of the MBC1/MBC3/MBC5 bank logic when the DUT
// accepts it. The monitor checks each translation against the oldest prediction.
// The mapper kind is only changed while nothing is in flight.
module cartridge_bank_mapper_unit_tb;

    import cbm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;   // unused code, acts as MBC5
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;        // pipeline is two deep
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_REQUESTS = 150;
    localparam int unsigned MAX_REPORTS    = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_data  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [KIND_W-1:0] cfg_data = '0;

    // requests waiting for the driver, translations waiting for the monitor
    req_item_t bus_requests[$];
    rsp_item_t expected_xlat[$];

    // idle percentages, changed between phases
    int unsigned send_idle_pct  = 20;
    int unsigned recv_stall_pct = 49;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // behavioral bank state, reset values
    logic [KIND_W-1:0]     kind_model    = KIND_MBC1;
    logic                  ram_on        = 1'b0;
    logic [ROM_BANK_W-1:0] rom_bank_sel  = ROM_BANK_RESET;
    logic [RAM_BANK_W-1:0] ram_bank_held = '0;
    logic [RAM_BANK_W-1:0] ram_bank_live = '0;
    logic                  mode_ram      = 1'b0;
    logic [DATA_W-1:0]     rtc_reg       = '0;

    rsp_item_t monitor_want;

    cartridge_bank_mapper_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Register write below 0x8000. Window is address bits 14:12.
    function automatic void update_banks(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        logic [2:0] win;
        logic [6:0] bank7;
        win = addr[14:12];
        if (win == WIN_RAMEN_0 || win == WIN_RAMEN_1)
        begin
            ram_on = ((data & RAM_EN_KEY) == RAM_EN_KEY);
        end
        else if (kind_model == KIND_MBC1)
        begin
            if (win == WIN_ROMB_LO || win == WIN_ROMB_HI)
                rom_bank_sel = (data[4:0] == 5'd0) ? ROM_BANK_RESET : {4'd0, data[4:0]};
            else if (win == WIN_RAMB_0 || win == WIN_RAMB_1)
                ram_bank_held = {2'd0, data[1:0]};
            else
                mode_ram = data[0];
            // mode 0: latch drives ROM bits 6:5 (replaced, not ORed)
            // mode 1: ROM bank cut to 5 bits, latch drives the RAM bank
            if (!mode_ram)
                rom_bank_sel = {2'd0, ram_bank_held[1:0], rom_bank_sel[4:0]};
            else
            begin
                rom_bank_sel  = {4'd0, rom_bank_sel[4:0]};
                ram_bank_live = ram_bank_held;
            end
        end
        else if (kind_model == KIND_MBC3)
        begin
            if (win == WIN_ROMB_LO || win == WIN_ROMB_HI)
            begin
                bank7 = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
                rom_bank_sel = {2'd0, bank7};
            end
            else if (win == WIN_RAMB_0 || win == WIN_RAMB_1)
            begin
                if (data > 8'd3)
                    rtc_reg = data;
                else
                begin
                    rtc_reg       = '0;
                    ram_bank_held = {2'd0, data[1:0]};
                    ram_bank_live = ram_bank_held;
                end
            end
            // 0x6000-0x7FFF ignored
        end
        else
        begin
            // MBC5 and the spare code; bank 0 is legal
            if (win == WIN_ROMB_LO)
                rom_bank_sel[7:0] = data;
            else if (win == WIN_ROMB_HI)
                rom_bank_sel[8] = data[0];
            else if (win == WIN_RAMB_0 || win == WIN_RAMB_1)
            begin
                ram_bank_held = data[3:0];
                ram_bank_live = ram_bank_held;
            end
        end
    endfunction

    // Translation of one accepted request; bank writes take effect here.
    function automatic rsp_item_t translate_access(req_item_t rq);
        rsp_item_t             res;
        logic [ROM_BANK_W-1:0] bank;
        res        = '0;
        res.target = TGT_NONE;
        if (!rq.bus_address[15])
        begin
            if (rq.command == CMD_WRITE)
            begin
                update_banks(rq.bus_address, rq.write_data);
                res.target = TGT_REG;
            end
            else
            begin
                // fixed area 0x0000-0x3FFF always bank 0
                bank = rq.bus_address[14] ? rom_bank_sel : '0;
                res.target      = TGT_ROM;
                res.rom_address = {bank, rq.bus_address[ROM_OFS_W-1:0]};
            end
        end
        else if (rq.bus_address[15:13] == 3'b101)
        begin
            // disabled RAM still translates, only flags the error
            res.target             = TGT_RAM;
            res.ram_address        = {ram_bank_live, rq.bus_address[RAM_OFS_W-1:0]};
            res.read_zero          = (kind_model == KIND_MBC3) && (rtc_reg != '0);
            res.ram_disabled_error = !ram_on;
        end
        return res;
    endfunction

    function automatic void queue_request(logic cmd, logic [ADDR_W-1:0] addr,
                                          logic [DATA_W-1:0] data);
        req_item_t rq;
        rq.command     = cmd;
        rq.bus_address = addr;
        rq.write_data  = data;
        bus_requests.push_back(rq);
    endfunction

    // Mostly well-formed traffic: bank writes with useful data, ROM and RAM
    // accesses, plus a slice of fully random requests.
    function automatic req_item_t random_request();
        req_item_t   rq;
        int unsigned region;
        rq.command     = 1'($urandom);
        rq.bus_address = 16'($urandom);
        rq.write_data  = 8'($urandom);
        region = $urandom_range(99);
        if (region < 40)
        begin
            rq.command         = CMD_WRITE;
            rq.bus_address[15] = 1'b0;
            case ($urandom_range(4))
                0: rq.write_data = rq.write_data | RAM_EN_KEY;
                1: rq.write_data = 8'($urandom_range(3));
                2: rq.write_data = 8'($urandom_range(7));
                3: rq.write_data = rq.write_data & 8'h80;   // zero bank request
                default: ;
            endcase
        end
        else if (region < 65)
        begin
            rq.command         = CMD_READ;
            rq.bus_address[15] = 1'b0;
        end
        else if (region < 90)
        begin
            rq.bus_address[15:13] = 3'b101;
        end
        return rq;
    endfunction

    // Driver: a request that is held stays put; a free slot is refilled from
    // the queue unless the sender idles this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_xlat.push_back(translate_access(req_data));
            if (!req_valid || req_ready)
            begin
                if (bus_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_data  <= bus_requests.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string what, rsp_item_t want, rsp_item_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected tgt=%0d rom=%h ram=%h rz=%b err=%b, got tgt=%0d rom=%h ram=%h rz=%b err=%b",
                     $realtime, what, want.target, want.rom_address, want.ram_address,
                     want.read_zero, want.ram_disabled_error, got.target, got.rom_address,
                     got.ram_address, got.read_zero, got.ram_disabled_error);
    endtask

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_xlat.size() == 0)
                report_mismatch("result with no request pending", '0, rsp_data);
            else
            begin
                monitor_want = expected_xlat.pop_front();
                if (rsp_data.target             !== monitor_want.target      ||
                    rsp_data.rom_address        !== monitor_want.rom_address ||
                    rsp_data.ram_address        !== monitor_want.ram_address ||
                    rsp_data.read_zero          !== monitor_want.read_zero   ||
                    rsp_data.ram_disabled_error !== monitor_want.ram_disabled_error)
                    report_mismatch("translation mismatch", monitor_want, rsp_data);
            end
        end
    end

    // Watchdog: too long without any handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Wait until every queued request is accepted and answered, then let the
    // pipeline settle.
    task automatic wait_idle();
        while (bus_requests.size() != 0 || req_valid || expected_xlat.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mapper kind write; only called while idle
    task automatic set_mapper(logic [KIND_W-1:0] kind);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= kind;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        kind_model  = kind;
    endtask

    initial
    begin
        logic [KIND_W-1:0] phase_kind [RANDOM_PHASES];
        phase_kind = '{KIND_MBC1, KIND_MBC3, KIND_MBC5, KIND_SPARE,
                       KIND_MBC5, KIND_MBC1, KIND_SPARE, KIND_MBC3};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // MBC1 straight out of reset
        queue_request(CMD_READ,  16'h0000, 8'h00);   // fixed bank
        queue_request(CMD_READ,  16'h4000, 8'h00);   // reset bank 1
        queue_request(CMD_READ,  16'hA000, 8'h00);   // RAM still disabled
        queue_request(CMD_WRITE, 16'h0000, 8'h0A);
        queue_request(CMD_READ,  16'hBFFF, 8'h00);
        queue_request(CMD_WRITE, 16'h2000, 8'h00);   // zero bank becomes one
        queue_request(CMD_WRITE, 16'h3FFF, 8'hFF);
        queue_request(CMD_WRITE, 16'h4000, 8'h03);   // upper ROM bits in mode 0
        queue_request(CMD_READ,  16'h7FFF, 8'h00);
        queue_request(CMD_WRITE, 16'h6000, 8'h01);   // mode 1: RAM bank from latch
        queue_request(CMD_WRITE, 16'hBFFF, 8'hFF);
        queue_request(CMD_WRITE, 16'hFFFF, 8'h00);   // console space
        queue_request(CMD_WRITE, 16'h1FFF, 8'hF5);   // disable again
        wait_idle();

        set_mapper(KIND_MBC3);
        queue_request(CMD_WRITE, 16'h2000, 8'h80);   // low 7 bits zero
        queue_request(CMD_READ,  16'h4000, 8'h00);
        queue_request(CMD_WRITE, 16'h4000, 8'h08);   // RTC select
        queue_request(CMD_READ,  16'hA000, 8'h00);
        queue_request(CMD_WRITE, 16'h5FFF, 8'h02);   // back to RAM bank
        queue_request(CMD_WRITE, 16'h7000, 8'hFF);   // ignored, still a reg write
        queue_request(CMD_WRITE, 16'h4000, 8'hFF);   // RTC left selected
        wait_idle();

        // RTC selection carries over but must not zero reads here
        set_mapper(KIND_MBC5);
        queue_request(CMD_WRITE, 16'h2000, 8'h00);   // bank 0 allowed
        queue_request(CMD_READ,  16'h4000, 8'h00);
        queue_request(CMD_WRITE, 16'h3000, 8'h01);
        queue_request(CMD_WRITE, 16'h2FFF, 8'hFF);
        queue_request(CMD_WRITE, 16'h0000, 8'hFF);
        queue_request(CMD_WRITE, 16'h4000, 8'h0F);
        queue_request(CMD_READ,  16'h7FFF, 8'h00);   // top ROM address
        queue_request(CMD_READ,  16'hBFFF, 8'h00);   // top RAM address
        wait_idle();

        // random traffic; bank state is shared across mapper changes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct  = 20;
                recv_stall_pct = 49;
            end
            else if (p < 6)
            begin
                send_idle_pct  = 49;
                recv_stall_pct = 20;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            set_mapper(phase_kind[p]);
            @(negedge clk);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                bus_requests.push_back(random_request());
            wait_idle();
        end

        if (mismatch_count == 0 && expected_xlat.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/cbm_pkg.sv
design/cbm_bank_regs.sv
design/cbm_translate.sv
design/cartridge_bank_mapper_unit.sv
test/cartridge_bank_mapper_unit_tb.sv
